// ===== rtl/core/sem_pkg.sv =====
package sem_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int FILL_W    = COL_W + 1;
	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int OCOL_W    = 11;
	localparam int CFGW_W    = 12;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// register select is byte address bit 2
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFGW_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [ROW_W-1:0]  HEIGHT_RESET = 16'd480;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] window_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_entry_t;

	typedef struct packed {
		logic              en;
		logic [COL_W-1:0]  addr;
		line_entry_t       data;
	} line_wr_t;

	function automatic pix_t sobel_mag(input window_t w);
		logic [9:0]  t;
		logic [9:0]  b;
		logic [9:0]  rt;
		logic [9:0]  lf;
		logic [9:0]  dy;
		logic [9:0]  dx;
		logic [10:0] m;
		t  = {2'b00, w[0]} + {1'b0, w[1], 1'b0} + {2'b00, w[2]};
		b  = {2'b00, w[6]} + {1'b0, w[7], 1'b0} + {2'b00, w[8]};
		rt = {2'b00, w[2]} + {1'b0, w[5], 1'b0} + {2'b00, w[8]};
		lf = {2'b00, w[0]} + {1'b0, w[3], 1'b0} + {2'b00, w[6]};
		dy = (t >= b) ? t - b : b - t;
		dx = (rt >= lf) ? rt - lf : lf - rt;
		m  = {1'b0, dy} + {1'b0, dx};
		return (m > 11'd255) ? 8'hFF : m[7:0];
	endfunction

endpackage

// ===== rtl/core/sem_line_store.sv =====
module sem_line_store
	import sem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	input  line_wr_t         wr,
	output line_entry_t      rd_data
);

	line_entry_t       mem [MAX_WIDTH];
	line_entry_t       rdata_q;
	logic              hit_q;
	logic [FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Columns are always written in order from zero, so the written entries
	// form a prefix; anything at or past the fill count still reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (wr.en && ({1'b0, wr.addr} == fill_q)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (rd_en) begin
				hit_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	assign rd_data = hit_q ? rdata_q : '0;

endmodule

// ===== rtl/core/sobel_edge_magnitude_unit.sv =====
// Sobel 3x3 edge magnitude over a raster pixel stream. Each accepted sample
// is one 8-bit pixel; for every interior pixel the block returns
// min(|Gx|+|Gy|, 255) with the centre's row and column, once the pixel
// below-right of it has arrived, and flags the last interior pixel of the
// frame. Border pixels give no result. One sample is accepted per clock
// sustained while the output is not stalled; a result moves from stage 1
// through stage 2 into the output register. The rate is set by the line
// store, a single 2048 x 16 memory holding the two previous rows, read once
// when a sample is accepted and written back as it moves to stage 2. Two
// samples and one result can be in flight; a stalled result holds the
// samples behind it, so input stalls once both pipeline stages are full.
// Entries never written read as zero through a fill count, so no clearing
// pass follows reset. Width (clamped to 3..2048) and height (at least 3) are
// set through the APB port while the stream is idle.
module sobel_edge_magnitude_unit
	import sem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic [PIX_W-1:0]  sample,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [PIX_W-1:0]  magnitude,
	output logic [ROW_W-1:0]  out_row,
	output logic [OCOL_W-1:0] out_col,
	output logic              frame_end
);

	logic [CFGW_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic [COL_W-1:0]  width_last;
	logic [ROW_W-1:0]  height_last;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              line_end;
	logic              last_row;
	logic              accept;

	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	pix_t              sample_s1;
	logic              res_s1;
	logic [ROW_W-1:0]  orow_s1;
	logic [OCOL_W-1:0] ocol_s1;
	logic              fend_s1;

	logic              valid_s2;
	logic              res_s2;
	logic [ROW_W-1:0]  orow_s2;
	logic [OCOL_W-1:0] ocol_s2;
	logic              fend_s2;

	window_t           window_q;
	line_entry_t       rd_data;
	line_wr_t          wr;

	logic              result_valid_q;
	pix_t              magnitude_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [OCOL_W-1:0] out_col_q;
	logic              frame_end_q;

	logic              out_free;
	logic              go_s2;
	logic              free_s2;
	logic              go_s1;
	logic              free_s1;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFGW_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[ROW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(height_q);
		endcase
	end

	always_comb begin
		if (width_q < 12'd3) begin
			width_last = COL_W'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			width_last = COL_W'(width_q - 12'd1);
		end
		height_last = (height_q < 16'd3) ? 16'd2 : height_q - 16'd1;
	end

	// pipeline flow
	assign out_free     = !result_valid_q || !result_stall;
	assign go_s2        = valid_s2 && (!res_s2 || out_free);
	assign free_s2      = !valid_s2 || go_s2;
	assign go_s1        = valid_s1 && free_s2;
	assign free_s1      = !valid_s1 || go_s1;
	assign sample_stall = !free_s1;
	assign accept       = sample_valid && free_s1;

	assign line_end = col_q >= width_last;
	assign last_row = row_q >= height_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				if (line_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				valid_s2 <= 1'b1;
			end else if (go_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_q;
			sample_s1 <= sample;
			res_s1    <= (row_q >= 16'd2) && (col_q >= COL_W'(2));
			orow_s1   <= row_q - 1'b1;
			ocol_s1   <= OCOL_W'(col_q - 1'b1);
			fend_s1   <= line_end && last_row;
		end
		if (go_s1) begin
			res_s2  <= res_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			fend_s2 <= fend_s1;
			for (int r = 0; r < 3; r++) begin
				window_q[r*3+0] <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[2] <= rd_data.upper;
			window_q[5] <= rd_data.middle;
			window_q[8] <= sample_s1;
		end
	end

	// Consecutive samples never share a column, so the write-back of one
	// sample cannot collide with the read of the next.
	always_comb begin
		wr.en          = go_s1;
		wr.addr        = col_s1;
		wr.data.upper  = rd_data.middle;
		wr.data.middle = sample_s1;
	end

	sem_line_store u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr      (wr),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go_s2 && res_s2) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2 && res_s2) begin
			magnitude_q <= sobel_mag(window_q);
			out_row_q   <= orow_s2;
			out_col_q   <= ocol_s2;
			frame_end_q <= fend_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign magnitude    = magnitude_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign frame_end    = frame_end_q;

endmodule

// ===== rtl/core/sem_checker.sv =====
module sem_checker
	import sem_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic [PIX_W-1:0]  magnitude,
	input logic [ROW_W-1:0]  out_row,
	input logic [OCOL_W-1:0] out_col,
	input logic              frame_end
);

	// hold a stalled beat
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(magnitude) && $stable(out_row)
			&& $stable(out_col) && $stable(frame_end))
		else $error("stalled result payload changed");

	// reset empties the output register
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// after the last interior pixel, the next samples are in the new frame's top row
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && frame_end |=> !result_valid)
		else $error("result right after frame end");

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sem_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		pix_t             mag;
		logic [ROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic             last;
	} edge_t;

	class sobel_stream;
		logic [CFGW_W-1:0] width_reg;
		logic [ROW_W-1:0]  height_reg;
		pix_t              upper_line [MAX_WIDTH];
		pix_t              middle_line [MAX_WIDTH];
		pix_t              win [9];
		int unsigned       col_cnt;
		int unsigned       row_cnt;
		edge_t             pending_edges [$];
		int                mismatches;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_cnt    = 0;
			row_cnt    = 0;
			mismatches = 0;
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		function void set_reg(logic sel, logic [DATA_W-1:0] v);
			if (sel == REG_IMAGE_WIDTH)
				width_reg = v[CFGW_W-1:0];
			else
				height_reg = v[ROW_W-1:0];
		endfunction

		function logic [DATA_W-1:0] reg_value(logic sel);
			if (sel == REG_IMAGE_WIDTH)
				return DATA_W'(width_reg);
			return DATA_W'(height_reg);
		endfunction

		function void take_pixel(pix_t s);
			int unsigned w;
			int unsigned h;
			int unsigned col;
			int unsigned row;
			int unsigned t;
			int unsigned b;
			int unsigned rt;
			int unsigned lf;
			int unsigned m;
			bit          line_end;
			bit          last_row;
			pix_t        top;
			pix_t        mid;
			edge_t       e;
			w = width_reg;
			if (w < 3) w = 3;
			if (w > MAX_WIDTH) w = MAX_WIDTH;
			h = height_reg;
			if (h < 3) h = 3;
			col      = col_cnt;
			row      = row_cnt;
			line_end = col >= w - 1;
			last_row = row >= h - 1;
			if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;

			top = upper_line[col];
			mid = middle_line[col];
			upper_line[col]  = mid;
			middle_line[col] = s;

			// slide the window one column left, new column enters on the right
			for (int r = 0; r < 3; r++) begin
				win[r*3]   = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = s;

			if (row >= 2 && col >= 2) begin
				t  = win[0] + 2 * win[1] + win[2];
				b  = win[6] + 2 * win[7] + win[8];
				rt = win[2] + 2 * win[5] + win[8];
				lf = win[0] + 2 * win[3] + win[6];
				m  = ((t >= b) ? t - b : b - t) + ((rt >= lf) ? rt - lf : lf - rt);
				e.mag  = (m > 255) ? 8'hFF : m[7:0];
				e.row  = ROW_W'(row - 1);
				e.col  = OCOL_W'(col - 1);
				e.last = line_end && last_row;
				pending_edges.push_back(e);
			end

			if (line_end) begin
				col_cnt = 0;
				row_cnt = last_row ? 0 : ((row + 1) & 16'hFFFF);
			end else begin
				col_cnt = col + 1;
			end
		endfunction

		task match_result(pix_t mag, logic [ROW_W-1:0] row,
				logic [OCOL_W-1:0] col, logic last);
			edge_t e;
			if (pending_edges.size() == 0) begin
				report($sformatf("unexpected result mag=%0d row=%0d col=%0d end=%0b",
					mag, row, col, last));
				return;
			end
			e = pending_edges.pop_front();
			if (mag !== e.mag)
				report($sformatf("magnitude %0d, want %0d at row %0d col %0d",
					mag, e.mag, e.row, e.col));
			if (row !== e.row)
				report($sformatf("out_row %0d, want %0d", row, e.row));
			if (col !== e.col)
				report($sformatf("out_col %0d, want %0d", col, e.col));
			if (last !== e.last)
				report($sformatf("frame_end %0b, want %0b at row %0d col %0d",
					last, e.last, e.row, e.col));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	logic [PIX_W-1:0]  sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [PIX_W-1:0]  magnitude;
	logic [ROW_W-1:0]  out_row;
	logic [OCOL_W-1:0] out_col;
	logic              frame_end;

	sobel_stream sb = new();
	int          cycles = 0;
	int          rx_tick = 0;

	sobel_edge_magnitude_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.magnitude    (magnitude),
		.out_row      (out_row),
		.out_col      (out_col),
		.frame_end    (frame_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: free flow, sparse random, periodic burst and heavy random stalls
	always @(negedge clk) begin
		rx_tick++;
		case ((rx_tick / 97) % 4)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ((rx_tick % 9) < 4);
			default: result_stall <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.match_result(magnitude, out_row, out_col, frame_end);
	end

	task automatic write_reg(logic sel, logic [DATA_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(sel, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(logic sel);
		logic [DATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(sel))
			sb.report($sformatf("register %0d reads %0d, want %0d",
				sel, got, sb.reg_value(sel)));
	endtask

	task automatic push_pixel(pix_t s);
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sb.take_pixel(s);
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (sb.pending_edges.size() != 0) @(posedge clk);
	endtask

	// quiet stream, then reprogram the frame size
	task automatic configure(logic [CFGW_W-1:0] w, logic [ROW_W-1:0] h);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
		write_reg(REG_IMAGE_HEIGHT, DATA_W'(h));
		check_reg(REG_IMAGE_WIDTH);
		check_reg(REG_IMAGE_HEIGHT);
	endtask

	function automatic pix_t pick_pixel(pix_t prev);
		int v;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1: begin
				// smooth area: a small step from the previous pixel, clamped to 0..255
				v = int'(prev) + int'($urandom_range(0, 8)) - 4;
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				return pix_t'(v);
			end
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_pixels(int n, bit pause_mid);
		int   burst;
		pix_t prev;
		burst = 0;
		prev  = 8'h80;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				drain_results();
			if (burst == 0) begin
				burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 12);
				hold_off($urandom_range(0, 6));
			end
			prev = pick_pixel(prev);
			push_pixel(prev);
			burst--;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_reg(REG_IMAGE_WIDTH);
		check_reg(REG_IMAGE_HEIGHT);

		// 3x3 frames from below-range settings: one result each, frame end set
		configure(12'd1, 16'd0);
		for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
		for (int i = 0; i < 9; i++) push_pixel(8'h00);
		for (int i = 0; i < 9; i++) push_pixel(pix_t'(i + 1));

		// narrow and very tall
		configure(12'd2, 16'hFFFF);
		random_pixels(240, 1'b0);
		// small frames, many frame ends; pause mid-stream until results drain
		configure(12'd7, 16'd5);
		random_pixels(250, 1'b1);
		// widest line, partial row only
		configure(12'hFFF, 16'd3);
		random_pixels(300, 1'b0);
		// shrink mid-line: counters wrap back into range
		configure(12'd6, 16'd4);
		random_pixels(150, 1'b0);
		configure(12'd40, 16'd3);
		random_pixels(200, 1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_edges.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
